// ===== rtl/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// No dependencies; the files that use it refer to it by scoped names.
package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Product slots carried along the multiplier row.
  localparam int P_RR = 0;
  localparam int P_II = 1;
  localparam int P_RI = 2;
  localparam int P_IR = 3;
  localparam int P_DR = 4;
  localparam int P_DI = 5;
  localparam int NPROD = 6;

  typedef struct packed {
    cmd_t cmd;
    logic dz;
    logic ov;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } ctl_t;

endpackage

// ===== rtl/complex_arith_unit.sv =====
// Top level of the complex arithmetic unit: multiplier row, setup stages, divider row
// and output register. Depends on cau_pkg, cau_mul_cell, cau_prep and cau_div_cell.
//
//   channel | signals                                   | direction
//   input   | in_valid, in_ready, cmd, a_re, a_im, b_re, b_im | request in
//   output  | out_valid, out_ready, res_re, res_im, div_zero, overflow | result out
//
// One request is taken per cycle unless a stall holds the input; each request passes
// through the DATA_WIDTH cells of the multiplier row, the two setup stages, the
// DATA_WIDTH cells of the divider row and the output register.
// Reset empties every stage. A stall at the output holds only the stages that are
// full; empty stages upstream keep taking requests.
module complex_arith_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] cmd,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic div_zero,
  output logic overflow
);

  localparam int W = DATA_WIDTH;

  logic m_v [0:W];
  logic m_rdy [0:W];
  cau_pkg::cmd_t m_cmd [0:W];
  logic [W-1:0] m_ar [0:W];
  logic [W-1:0] m_ai [0:W];
  logic [W-1:0] m_br [0:W];
  logic [W-1:0] m_bi [0:W];
  logic [cau_pkg::NPROD-1:0][2*W-1:0] m_acc [0:W];

  assign m_v[0] = in_valid;
  assign in_ready = m_rdy[0];
  assign m_cmd[0] = cau_pkg::cmd_t'(cmd);
  assign m_ar[0] = a_re;
  assign m_ai[0] = a_im;
  assign m_br[0] = b_re;
  assign m_bi[0] = b_im;
  assign m_acc[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_mul
    cau_mul_cell #(.W(W), .IDX(i)) u_cell (
      .clk(clk), .rst(rst),
      .in_v(m_v[i]), .in_rdy(m_rdy[i]), .in_cmd(m_cmd[i]),
      .in_ar(m_ar[i]), .in_ai(m_ai[i]), .in_br(m_br[i]), .in_bi(m_bi[i]),
      .in_acc(m_acc[i]),
      .out_v(m_v[i+1]), .out_rdy(m_rdy[i+1]), .out_cmd(m_cmd[i+1]),
      .out_ar(m_ar[i+1]), .out_ai(m_ai[i+1]), .out_br(m_br[i+1]), .out_bi(m_bi[i+1]),
      .out_acc(m_acc[i+1])
    );
  end

  logic d_v [0:W];
  logic d_rdy [0:W];
  cau_pkg::ctl_t d_ctl [0:W];
  logic [2*W-1:0] d_d [0:W];
  logic [2*W-1:0] d_rem_re [0:W];
  logic [2*W-1:0] d_rem_im [0:W];
  logic [W-1:0] d_nlo_re [0:W];
  logic [W-1:0] d_nlo_im [0:W];
  logic [W-1:0] d_q_re [0:W];
  logic [W-1:0] d_q_im [0:W];
  logic [W-1:0] d_res_re [0:W];
  logic [W-1:0] d_res_im [0:W];

  cau_prep #(.W(W), .F(FRAC_BITS)) u_prep (
    .clk(clk), .rst(rst),
    .in_v(m_v[W]), .in_rdy(m_rdy[W]), .in_cmd(m_cmd[W]),
    .in_ar(m_ar[W]), .in_ai(m_ai[W]), .in_br(m_br[W]), .in_bi(m_bi[W]),
    .in_acc(m_acc[W]),
    .out_v(d_v[0]), .out_rdy(d_rdy[0]), .out_ctl(d_ctl[0]), .out_d(d_d[0]),
    .out_rem_re(d_rem_re[0]), .out_rem_im(d_rem_im[0]),
    .out_nlo_re(d_nlo_re[0]), .out_nlo_im(d_nlo_im[0]),
    .out_res_re(d_res_re[0]), .out_res_im(d_res_im[0])
  );

  assign d_q_re[0] = '0;
  assign d_q_im[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    cau_div_cell #(.W(W)) u_cell (
      .clk(clk), .rst(rst),
      .in_v(d_v[i]), .in_rdy(d_rdy[i]), .in_ctl(d_ctl[i]), .in_d(d_d[i]),
      .in_rem_re(d_rem_re[i]), .in_rem_im(d_rem_im[i]),
      .in_nlo_re(d_nlo_re[i]), .in_nlo_im(d_nlo_im[i]),
      .in_q_re(d_q_re[i]), .in_q_im(d_q_im[i]),
      .in_res_re(d_res_re[i]), .in_res_im(d_res_im[i]),
      .out_v(d_v[i+1]), .out_rdy(d_rdy[i+1]), .out_ctl(d_ctl[i+1]), .out_d(d_d[i+1]),
      .out_rem_re(d_rem_re[i+1]), .out_rem_im(d_rem_im[i+1]),
      .out_nlo_re(d_nlo_re[i+1]), .out_nlo_im(d_nlo_im[i+1]),
      .out_q_re(d_q_re[i+1]), .out_q_im(d_q_im[i+1]),
      .out_res_re(d_res_re[i+1]), .out_res_im(d_res_im[i+1])
    );
  end

  cau_pkg::ctl_t fc;
  logic [W-1:0] max_v, min_v;
  logic [1:0][W-1:0] q, part, res_next;
  logic [1:0] neg, big, sat;
  logic ov_next;

  assign fc = d_ctl[W];
  assign max_v = {1'b0, {(W-1){1'b1}}};
  assign min_v = {1'b1, {(W-1){1'b0}}};
  assign q = {d_q_im[W], d_q_re[W]};
  assign part = {d_res_im[W], d_res_re[W]};
  assign neg = {fc.neg_im, fc.neg_re};
  assign big = {fc.big_im, fc.big_re};

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sat[k] = 1'b0;
      if (fc.cmd != cau_pkg::CMD_DIV) begin
        res_next[k] = part[k];
      end else if (fc.dz) begin
        res_next[k] = '0;
      end else if (big[k]) begin
        sat[k] = 1'b1;
        res_next[k] = neg[k] ? min_v : max_v;
      end else if (!neg[k]) begin
        sat[k] = q[k] > max_v;
        res_next[k] = sat[k] ? max_v : q[k];
      end else begin
        sat[k] = q[k] > min_v;
        res_next[k] = sat[k] ? min_v : ((~q[k]) + {{(W-1){1'b0}}, 1'b1});
      end
    end
    ov_next = (fc.cmd == cau_pkg::CMD_DIV) ? (|sat) : fc.ov;
  end

  assign d_rdy[W] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_rdy[W]) begin
      out_valid <= d_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy[W] && d_v[W]) begin
      res_re   <= res_next[0];
      res_im   <= res_next[1];
      div_zero <= fc.dz;
      overflow <= ov_next;
    end
  end

endmodule

// ===== rtl/cau_mul_cell.sv =====
// One cell of the multiplier row: adds one partial product to each of six products (the last cell subtracts it).
// Depends on cau_pkg.
module cau_mul_cell #(
  parameter int W = 32,
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  output logic in_rdy,
  input  cau_pkg::cmd_t in_cmd,
  input  logic [W-1:0] in_ar,
  input  logic [W-1:0] in_ai,
  input  logic [W-1:0] in_br,
  input  logic [W-1:0] in_bi,
  input  logic [cau_pkg::NPROD-1:0][2*W-1:0] in_acc,
  output logic out_v,
  input  logic out_rdy,
  output cau_pkg::cmd_t out_cmd,
  output logic [W-1:0] out_ar,
  output logic [W-1:0] out_ai,
  output logic [W-1:0] out_br,
  output logic [W-1:0] out_bi,
  output logic [cau_pkg::NPROD-1:0][2*W-1:0] out_acc
);

  localparam bit LAST = (IDX == W - 1);

  logic [cau_pkg::NPROD-1:0][W-1:0] mcand;
  logic [cau_pkg::NPROD-1:0][W-1:0] mplier;
  logic [cau_pkg::NPROD-1:0][2*W-1:0] acc_next;

  assign in_rdy = !out_v || out_rdy;

  always_comb begin
    mcand[cau_pkg::P_RR] = in_ar;  mplier[cau_pkg::P_RR] = in_br;
    mcand[cau_pkg::P_II] = in_ai;  mplier[cau_pkg::P_II] = in_bi;
    mcand[cau_pkg::P_RI] = in_ar;  mplier[cau_pkg::P_RI] = in_bi;
    mcand[cau_pkg::P_IR] = in_ai;  mplier[cau_pkg::P_IR] = in_br;
    mcand[cau_pkg::P_DR] = in_br;  mplier[cau_pkg::P_DR] = in_br;
    mcand[cau_pkg::P_DI] = in_bi;  mplier[cau_pkg::P_DI] = in_bi;
  end

  always_comb begin
    logic [2*W-1:0] term;
    for (int k = 0; k < cau_pkg::NPROD; k++) begin
      term = {{W{mcand[k][W-1]}}, mcand[k]} << IDX;
      if (!mplier[k][IDX]) begin
        acc_next[k] = in_acc[k];
      end else if (LAST) begin
        acc_next[k] = in_acc[k] - term;
      end else begin
        acc_next[k] = in_acc[k] + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (in_rdy) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_v) begin
      out_cmd <= in_cmd;
      out_ar  <= in_ar;
      out_ai  <= in_ai;
      out_br  <= in_br;
      out_bi  <= in_bi;
      out_acc <= acc_next;
    end
  end

endmodule

// ===== rtl/cau_prep.sv =====
// Two stages between the rows: sums, saturation of add, subtract and multiply,
// and the divider setup (magnitudes, denominator, range check). Depends on cau_pkg.
module cau_prep #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  output logic in_rdy,
  input  cau_pkg::cmd_t in_cmd,
  input  logic [W-1:0] in_ar,
  input  logic [W-1:0] in_ai,
  input  logic [W-1:0] in_br,
  input  logic [W-1:0] in_bi,
  input  logic [cau_pkg::NPROD-1:0][2*W-1:0] in_acc,
  output logic out_v,
  input  logic out_rdy,
  output cau_pkg::ctl_t out_ctl,
  output logic [2*W-1:0] out_d,
  output logic [2*W-1:0] out_rem_re,
  output logic [2*W-1:0] out_rem_im,
  output logic [W-1:0] out_nlo_re,
  output logic [W-1:0] out_nlo_im,
  output logic [W-1:0] out_res_re,
  output logic [W-1:0] out_res_im
);

  localparam int NW = 2 * W + F;
  localparam int CW = (W + F > 2 * W) ? (W + F) : (2 * W);

  logic s1_v;
  logic s1_rdy;
  cau_pkg::cmd_t s1_cmd;
  logic [W:0] s1_re_as, s1_im_as;
  logic [2*W:0] s1_mre, s1_mim, s1_nr, s1_ni;
  logic [2*W-1:0] s1_d;

  logic [W:0] re_as, im_as;
  logic [2*W-1:0] rr, ii, ri, ir, dr, di;

  assign in_rdy = !s1_v || s1_rdy;
  assign s1_rdy = !out_v || out_rdy;

  assign rr = in_acc[cau_pkg::P_RR];
  assign ii = in_acc[cau_pkg::P_II];
  assign ri = in_acc[cau_pkg::P_RI];
  assign ir = in_acc[cau_pkg::P_IR];
  assign dr = in_acc[cau_pkg::P_DR];
  assign di = in_acc[cau_pkg::P_DI];

  always_comb begin
    if (in_cmd == cau_pkg::CMD_SUB) begin
      re_as = {in_ar[W-1], in_ar} - {in_br[W-1], in_br};
      im_as = {in_ai[W-1], in_ai} - {in_bi[W-1], in_bi};
    end else begin
      re_as = {in_ar[W-1], in_ar} + {in_br[W-1], in_br};
      im_as = {in_ai[W-1], in_ai} + {in_bi[W-1], in_bi};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_rdy) begin
      s1_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_v) begin
      s1_cmd   <= in_cmd;
      s1_re_as <= re_as;
      s1_im_as <= im_as;
      s1_mre   <= {rr[2*W-1], rr} - {ii[2*W-1], ii};
      s1_mim   <= {ri[2*W-1], ri} + {ir[2*W-1], ir};
      s1_nr    <= {rr[2*W-1], rr} + {ii[2*W-1], ii};
      s1_ni    <= {ir[2*W-1], ir} - {ri[2*W-1], ri};
      s1_d     <= dr + di;
    end
  end

  logic [W-1:0] max_v, min_v;
  logic signed [2*W:0] sh_re, sh_im;
  logic [W+1:0] hi_re, hi_im;
  logic [2*W:0] abs_re, abs_im;
  logic [NW-1:0] n_re, n_im;
  logic [CW-1:0] nhi_re, nhi_im;
  logic big_re, big_im;
  cau_pkg::ctl_t ctl;
  logic [W-1:0] res_re, res_im;

  assign max_v = {1'b0, {(W-1){1'b1}}};
  assign min_v = {1'b1, {(W-1){1'b0}}};
  assign sh_re = $signed(s1_mre) >>> F;
  assign sh_im = $signed(s1_mim) >>> F;
  assign hi_re = sh_re[2*W:W-1];
  assign hi_im = sh_im[2*W:W-1];
  assign abs_re = s1_nr[2*W] ? ((~s1_nr) + {{(2*W){1'b0}}, 1'b1}) : s1_nr;
  assign abs_im = s1_ni[2*W] ? ((~s1_ni) + {{(2*W){1'b0}}, 1'b1}) : s1_ni;
  assign n_re = NW'(abs_re[2*W-1:0]) << F;
  assign n_im = NW'(abs_im[2*W-1:0]) << F;
  assign nhi_re = CW'(n_re[NW-1:W]);
  assign nhi_im = CW'(n_im[NW-1:W]);
  assign big_re = nhi_re >= CW'(s1_d);
  assign big_im = nhi_im >= CW'(s1_d);

  always_comb begin
    ctl.cmd = s1_cmd;
    ctl.dz = (s1_cmd == cau_pkg::CMD_DIV) && (s1_d == '0);
    ctl.neg_re = s1_nr[2*W];
    ctl.neg_im = s1_ni[2*W];
    ctl.big_re = big_re;
    ctl.big_im = big_im;
    ctl.ov = 1'b0;
    res_re = '0;
    res_im = '0;
    unique case (s1_cmd)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
        res_re = (s1_re_as[W] != s1_re_as[W-1]) ? (s1_re_as[W] ? min_v : max_v)
                                                : s1_re_as[W-1:0];
        res_im = (s1_im_as[W] != s1_im_as[W-1]) ? (s1_im_as[W] ? min_v : max_v)
                                                : s1_im_as[W-1:0];
        ctl.ov = (s1_re_as[W] != s1_re_as[W-1]) || (s1_im_as[W] != s1_im_as[W-1]);
      end
      cau_pkg::CMD_MUL: begin
        res_re = (&hi_re || !(|hi_re)) ? sh_re[W-1:0] : (sh_re[2*W] ? min_v : max_v);
        res_im = (&hi_im || !(|hi_im)) ? sh_im[W-1:0] : (sh_im[2*W] ? min_v : max_v);
        ctl.ov = !(&hi_re || !(|hi_re)) || !(&hi_im || !(|hi_im));
      end
      cau_pkg::CMD_DIV: begin
        res_re = '0;
        res_im = '0;
      end
      default: begin
        res_re = '0;
        res_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s1_rdy) begin
      out_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && s1_v) begin
      out_ctl    <= ctl;
      out_d      <= s1_d;
      out_rem_re <= big_re ? '0 : nhi_re[2*W-1:0];
      out_rem_im <= big_im ? '0 : nhi_im[2*W-1:0];
      out_nlo_re <= n_re[W-1:0];
      out_nlo_im <= n_im[W-1:0];
      out_res_re <= res_re;
      out_res_im <= res_im;
    end
  end

endmodule

// ===== rtl/cau_div_cell.sv =====
// One cell of the divider row: one restoring quotient bit for each of the two quotients.
// Depends on cau_pkg.
module cau_div_cell #(
  parameter int W = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_v,
  output logic in_rdy,
  input  cau_pkg::ctl_t in_ctl,
  input  logic [2*W-1:0] in_d,
  input  logic [2*W-1:0] in_rem_re,
  input  logic [2*W-1:0] in_rem_im,
  input  logic [W-1:0] in_nlo_re,
  input  logic [W-1:0] in_nlo_im,
  input  logic [W-1:0] in_q_re,
  input  logic [W-1:0] in_q_im,
  input  logic [W-1:0] in_res_re,
  input  logic [W-1:0] in_res_im,
  output logic out_v,
  input  logic out_rdy,
  output cau_pkg::ctl_t out_ctl,
  output logic [2*W-1:0] out_d,
  output logic [2*W-1:0] out_rem_re,
  output logic [2*W-1:0] out_rem_im,
  output logic [W-1:0] out_nlo_re,
  output logic [W-1:0] out_nlo_im,
  output logic [W-1:0] out_q_re,
  output logic [W-1:0] out_q_im,
  output logic [W-1:0] out_res_re,
  output logic [W-1:0] out_res_im
);

  logic [2*W:0] t_re, t_im, dx, dif_re, dif_im;
  logic ge_re, ge_im;

  assign in_rdy = !out_v || out_rdy;
  assign dx = {1'b0, in_d};
  assign t_re = {in_rem_re, in_nlo_re[W-1]};
  assign t_im = {in_rem_im, in_nlo_im[W-1]};
  assign ge_re = t_re >= dx;
  assign ge_im = t_im >= dx;
  assign dif_re = ge_re ? (t_re - dx) : t_re;
  assign dif_im = ge_im ? (t_im - dx) : t_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (in_rdy) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_v) begin
      out_ctl    <= in_ctl;
      out_d      <= in_d;
      out_rem_re <= dif_re[2*W-1:0];
      out_rem_im <= dif_im[2*W-1:0];
      out_nlo_re <= in_nlo_re << 1;
      out_nlo_im <= in_nlo_im << 1;
      out_q_re   <= {in_q_re[W-2:0], ge_re};
      out_q_im   <= {in_q_im[W-2:0], ge_im};
      out_res_re <= in_res_re;
      out_res_im <= in_res_im;
    end
  end

endmodule

// ===== rtl/cau_check.sv =====
// Port-level checks of the complex arithmetic unit and the bind that attaches them.
// Depends on complex_arith_unit.
module cau_check #(
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [DATA_WIDTH-1:0] res_re,
  input logic signed [DATA_WIDTH-1:0] res_im,
  input logic div_zero,
  input logic overflow
);

  logic [DATA_WIDTH-1:0] max_v, min_v;

  assign max_v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  assign min_v = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(res_re) && $stable(res_im))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
    else $error("division by zero result is not zero");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      (res_re == max_v || res_re == min_v || res_im == max_v || res_im == min_v))
    else $error("overflow without a saturated part");

endmodule

bind complex_arith_unit cau_check #(.DATA_WIDTH(DATA_WIDTH)) u_cau_check (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflow(overflow)
);

// ===== tb/sv/cau_checker.sv =====
`timescale 1ns / 1ps
// Checker for the complex arithmetic unit: watches both channels, predicts each result
// from the accepted request and compares it field by field. Depends on cau_pkg.
module cau_checker #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [1:0] cmd,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  input  logic out_valid,
  input  logic out_ready,
  input  logic signed [DATA_WIDTH-1:0] res_re,
  input  logic signed [DATA_WIDTH-1:0] res_im,
  input  logic div_zero,
  input  logic overflow,
  output int errors,
  output int pending,
  output int results_seen,
  output int div_zero_seen,
  output int overflow_seen
);

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic dz;
    logic ov;
  } cplx_result_t;

  cplx_result_t result_q[$];

  function automatic logic signed [DATA_WIDTH-1:0] clamp(input wide_t x, inout logic ov);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -(wide_t'(1) <<< (DATA_WIDTH - 1));
    if (x > hi) begin
      ov = 1'b1;
      return hi[DATA_WIDTH-1:0];
    end
    if (x < lo) begin
      ov = 1'b1;
      return lo[DATA_WIDTH-1:0];
    end
    return x[DATA_WIDTH-1:0];
  endfunction

  // Signed division truncates toward zero, as the hardware does.
  function automatic wide_t quot(input wide_t num, input wide_t den);
    wide_t mag;
    mag = num < 0 ? -num : num;
    mag = (mag <<< FRAC_BITS) / den;
    return num < 0 ? -mag : mag;
  endfunction

  function automatic cplx_result_t complex_op(input cau_pkg::cmd_t op,
      input wide_t ar, input wide_t ai, input wide_t br, input wide_t bi);
    cplx_result_t r;
    wide_t re;
    wide_t im;
    wide_t den;
    logic ov;
    ov = 1'b0;
    r.dz = 1'b0;
    case (op)
      cau_pkg::CMD_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::CMD_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::CMD_MUL: begin
        re = (ar * br - ai * bi) >>> FRAC_BITS;
        im = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
          re = 0;
          im = 0;
        end else begin
          re = quot(ar * br + ai * bi, den);
          im = quot(ai * br - ar * bi, den);
        end
      end
    endcase
    r.re = clamp(re, ov);
    r.im = clamp(im, ov);
    r.ov = ov;
    return r;
  endfunction

  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (rst) begin
      errors <= 0;
      pending <= 0;
      results_seen <= 0;
      div_zero_seen <= 0;
      overflow_seen <= 0;
      result_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        result_q.push_back(complex_op(cau_pkg::cmd_t'(cmd), wide_t'(a_re), wide_t'(a_im),
            wide_t'(b_re), wide_t'(b_im)));
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        div_zero_seen <= div_zero_seen + div_zero;
        overflow_seen <= overflow_seen + overflow;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h", $time, res_re, res_im);
          errors <= errors + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (res_re !== exp_r.re || res_im !== exp_r.im || div_zero !== exp_r.dz ||
              overflow !== exp_r.ov) begin
            $display("%0t: mismatch expected re=%h im=%h dz=%b ov=%b", $time,
                exp_r.re, exp_r.im, exp_r.dz, exp_r.ov);
            $display("%0t:          actual   re=%h im=%h dz=%b ov=%b", $time,
                res_re, res_im, div_zero, overflow);
            errors <= errors + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_complex_arith_unit.sv =====
`timescale 1ns / 1ps
// Top of the complex arithmetic unit testbench: clock, reset, request stimulus, output
// stalls and the verdict. Depends on cau_pkg, complex_arith_unit and cau_checker.
module tb_complex_arith_unit;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * DW + 3;
  localparam int RAND_ITEMS = 830;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = '0;
  logic signed [DW-1:0] a_re = '0;
  logic signed [DW-1:0] a_im = '0;
  logic signed [DW-1:0] b_re = '0;
  logic signed [DW-1:0] b_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] res_re;
  logic signed [DW-1:0] res_im;
  logic div_zero;
  logic overflow;
  int errors;
  int pending;
  int results_seen;
  int div_zero_seen;
  int overflow_seen;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  complex_arith_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .out_valid(out_valid),
    .out_ready(out_ready), .res_re(res_re), .res_im(res_im), .div_zero(div_zero),
    .overflow(overflow)
  );

  cau_checker #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .out_valid(out_valid),
    .out_ready(out_ready), .res_re(res_re), .res_im(res_im), .div_zero(div_zero),
    .overflow(overflow), .errors(errors), .pending(pending),
    .results_seen(results_seen), .div_zero_seen(div_zero_seen),
    .overflow_seen(overflow_seen)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Watchdog expired with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic signed [DW-1:0] pick_part();
    case ($urandom_range(7))
      0: return {1'b1, {(DW - 1){1'b0}}};
      1: return {1'b0, {(DW - 1){1'b1}}};
      2: return '0;
      3: return DW'($signed($urandom_range(8)) - 4) <<< FB;
      4: return DW'($signed($urandom_range(2000)) - 1000);
      5: return DW'($signed($urandom_range(1 << 20)) - (1 << 19)) <<< 4;
      default: return DW'($urandom());
    endcase
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input cau_pkg::cmd_t op, input logic signed [DW-1:0] ar,
      input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
      input logic signed [DW-1:0] bi);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= op;
    a_re <= ar;
    a_im <= ai;
    b_re <= br;
    b_im <= bi;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  initial begin
    logic signed [DW-1:0] mx;
    logic signed [DW-1:0] mn;
    logic signed [DW-1:0] one;
    logic signed [DW-1:0] v;
    cau_pkg::cmd_t op;
    int k;
    mx = {1'b0, {(DW - 1){1'b1}}};
    mn = {1'b1, {(DW - 1){1'b0}}};
    one = 1 <<< FB;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(cau_pkg::CMD_ADD, mx, mn, mx, mn);
    send_request(cau_pkg::CMD_ADD, mx, mn, mn, mx);
    send_request(cau_pkg::CMD_SUB, mn, mx, mx, mn);
    send_request(cau_pkg::CMD_SUB, '0, '0, mn, mn);
    send_request(cau_pkg::CMD_MUL, one, one, one, -one);
    send_request(cau_pkg::CMD_MUL, mx, mx, mx, mx);
    send_request(cau_pkg::CMD_MUL, mn, mn, mn, mn);
    send_request(cau_pkg::CMD_MUL, -1, 1, 1, -1);
    send_request(cau_pkg::CMD_DIV, one, one, '0, '0);
    send_request(cau_pkg::CMD_DIV, mx, mn, '0, '0);
    send_request(cau_pkg::CMD_DIV, one, '0, one, one);
    send_request(cau_pkg::CMD_DIV, mx, mx, 1, '0);
    send_request(cau_pkg::CMD_DIV, mn, mn, mn, mn);
    send_request(cau_pkg::CMD_DIV, -one, '0, 3 <<< FB, '0);
    send_request(cau_pkg::CMD_DIV, 5, -7, mx, 1);
    send_request(cau_pkg::CMD_DIV, '1, '1, '1, '0);
    send_request(cau_pkg::CMD_ADD, '1, '1, '1, '1);
    send_request(cau_pkg::CMD_SUB, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
        32'h5555_5555);

    // Drain fully before the random part.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (k = 0; k < RAND_ITEMS; k++) begin
      calm = (k >= 300 && k < 400);
      if (k == 550) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      op = cau_pkg::cmd_t'($urandom_range(3));
      if (op == cau_pkg::CMD_DIV && $urandom_range(9) == 0) begin
        send_request(op, pick_part(), pick_part(), '0, '0);
      end else begin
        v = pick_part();
        send_request(op, pick_part(), pick_part(), v, pick_part());
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    k = 0;
    while (pending != 0 && k < 100 * LATENCY) begin
      @(posedge clk);
      k++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    $display("Ran %0d requests over all four operations: %0d results, %0d divide by zero,",
        RAND_ITEMS + 18, results_seen, div_zero_seen);
    $display("%0d saturated, with random stalls on both channels.", overflow_seen);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cau_pkg.sv
rtl/cau_mul_cell.sv
rtl/cau_prep.sv
rtl/cau_div_cell.sv
rtl/complex_arith_unit.sv
rtl/cau_check.sv
tb/sv/cau_checker.sv
tb/sv/tb_complex_arith_unit.sv
